// ===== rtl/core/gbns_pkg.sv =====
// ----------------------------------------------------------------------------
// gbns_pkg: shared types and constants
// Sizes, codes and control structs for the go-back-n sender window core.
// ----------------------------------------------------------------------------
package gbns_pkg;

  localparam int SEQ_SPACE  = 8;
  localparam int SEQ_W      = $clog2(SEQ_SPACE);
  localparam int WINDOW     = 7;
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int TAG_W      = 32;
  localparam int LIMIT_W    = 7;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);
  localparam logic [SEQ_W-1:0]   WIN_EFF     = SEQ_W'(WINDOW);
  localparam logic [CNT_W-1:0]   FIFO_CAP    = CNT_W'(FIFO_DEPTH);

  // register word index (byte address / 4)
  localparam logic REG_PENDING_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ACT_MSG     = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD,
    ST_EMIT,
    ST_DROP
  } state_t;

  // pending FIFO memory access
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [TAG_W-1:0] wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } pend_req_t;

  // in-flight tag memory access
  typedef struct packed {
    logic             we;
    logic [SEQ_W-1:0] waddr;
    logic [TAG_W-1:0] wdata;
    logic             re;
    logic [SEQ_W-1:0] raddr;
  } flight_req_t;

endpackage

// ===== rtl/core/gbns_ram.sv =====
// ----------------------------------------------------------------------------
// gbns_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbns_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/gbns_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbns_ctrl: window sequencer
// Decodes one input beat, then walks the FIFO or window one result a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gbns_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbns_pkg::LIMIT_W-1:0]  pending_limit,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [gbns_pkg::TAG_W-1:0]    in_message_tag,
  input  logic [gbns_pkg::SEQ_W-1:0]    in_ack_num,
  input  logic                          in_ack_corrupt,
  // memories
  output gbns_pkg::pend_req_t           pend_req,
  input  logic [gbns_pkg::TAG_W-1:0]    pend_rdata,
  output gbns_pkg::flight_req_t         flight_req,
  input  logic [gbns_pkg::TAG_W-1:0]    flight_rdata,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [gbns_pkg::SEQ_W-1:0]    out_seq_num,
  output logic [gbns_pkg::TAG_W-1:0]    out_out_tag,
  output logic                          out_last
);

  localparam int SW = gbns_pkg::SEQ_W;
  localparam int CW = gbns_pkg::CNT_W;
  localparam int PW = gbns_pkg::PTR_W;

  gbns_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]            base_r, next_r, left_r, ptr_r;
  logic [CW-1:0]            count_r;
  logic [PW-1:0]            head_r, tail_r;
  logic                     send_r;
  gbns_pkg::action_t        act_r;
  logic [gbns_pkg::TAG_W-1:0] tag_r;
  logic [SW-1:0]            ack_r;
  logic                     corrupt_r;

  logic                     out_valid_r, out_last_r;
  logic [1:0]               out_kind_r;
  logic [SW-1:0]            out_seq_r;
  logic [gbns_pkg::TAG_W-1:0] out_tag_r;

  // decode terms
  logic [CW-1:0] limit;
  logic [SW-1:0] in_flight, ack_off, ack_dup, ack_base, ack_flight, flight_after;
  logic          drop, win_open, is_dup, in_win, ack_send;
  logic          accept, slot_free, more;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    limit        = (CW'(pending_limit) > gbns_pkg::FIFO_CAP) ? gbns_pkg::FIFO_CAP
                                                             : CW'(pending_limit);
    in_flight    = next_r - base_r;
    drop         = count_r >= limit;
    win_open     = in_flight < gbns_pkg::WIN_EFF;
    ack_dup      = base_r - SW'(1);
    ack_off      = ack_r - base_r;
    ack_base     = ack_r + SW'(1);
    ack_flight   = next_r - ack_base;
    is_dup       = !corrupt_r && (ack_r == ack_dup);
    in_win       = !corrupt_r && !is_dup && (ack_off < in_flight);
    ack_send     = (count_r != '0) && (ack_flight < gbns_pkg::WIN_EFF);
    flight_after = next_r + SW'(1) - base_r;
    // another result follows the current one
    if (send_r) begin
      more = (left_r > SW'(1)) && (count_r > CW'(1)) && (flight_after < gbns_pkg::WIN_EFF);
    end else begin
      more = left_r > SW'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbns_pkg::ST_IDLE: begin
        if (accept) state_nxt = gbns_pkg::ST_EVAL;
      end
      gbns_pkg::ST_EVAL: begin
        case (act_r)
          gbns_pkg::ACT_MSG: begin
            if (drop)          state_nxt = gbns_pkg::ST_DROP;
            else if (win_open) state_nxt = gbns_pkg::ST_RD;
            else               state_nxt = gbns_pkg::ST_IDLE;
          end
          gbns_pkg::ACT_ACK: begin
            if (is_dup && in_flight != '0)   state_nxt = gbns_pkg::ST_RD;
            else if (in_win && ack_send)     state_nxt = gbns_pkg::ST_RD;
            else                             state_nxt = gbns_pkg::ST_IDLE;
          end
          gbns_pkg::ACT_TIMEOUT: begin
            if (in_flight != '0) state_nxt = gbns_pkg::ST_RD;
            else                 state_nxt = gbns_pkg::ST_IDLE;
          end
          default: state_nxt = gbns_pkg::ST_IDLE;
        endcase
      end
      gbns_pkg::ST_RD: state_nxt = gbns_pkg::ST_EMIT;
      gbns_pkg::ST_EMIT: begin
        if (slot_free && !more) state_nxt = gbns_pkg::ST_IDLE;
      end
      gbns_pkg::ST_DROP: begin
        if (slot_free) state_nxt = gbns_pkg::ST_IDLE;
      end
      default: state_nxt = gbns_pkg::ST_IDLE;
    endcase
  end

  // memory strobes
  always_comb begin
    in_stall         = (state_r != gbns_pkg::ST_IDLE);
    pend_req         = '0;
    flight_req       = '0;
    pend_req.waddr   = tail_r;
    pend_req.wdata   = tag_r;
    flight_req.waddr = next_r;
    flight_req.wdata = pend_rdata;
    pend_req.raddr   = head_r;
    flight_req.raddr = ptr_r;
    case (state_r)
      gbns_pkg::ST_EVAL: begin
        pend_req.we = (act_r == gbns_pkg::ACT_MSG) && !drop;
      end
      gbns_pkg::ST_RD: begin
        pend_req.re   = send_r;
        flight_req.re = !send_r;
      end
      gbns_pkg::ST_EMIT: begin
        // prefetch the following entry while this one goes out
        pend_req.raddr   = head_r + PW'(1);
        flight_req.raddr = ptr_r + SW'(1);
        pend_req.re      = slot_free && more && send_r;
        flight_req.re    = slot_free && more && !send_r;
        flight_req.we    = slot_free && send_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbns_pkg::ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a beat when the slot frees up, else clear a taken one
      if (((state_r == gbns_pkg::ST_EMIT) || (state_r == gbns_pkg::ST_DROP)) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        gbns_pkg::ST_EVAL: begin
          case (act_r)
            gbns_pkg::ACT_MSG: begin
              if (!drop) begin
                tail_r  <= tail_r + PW'(1);
                count_r <= count_r + CW'(1);
              end
            end
            gbns_pkg::ACT_ACK: begin
              if (in_win) base_r <= ack_base;
            end
            default: ;
          endcase
        end
        gbns_pkg::ST_EMIT: begin
          if (slot_free && send_r) begin
            head_r  <= head_r + PW'(1);
            count_r <= count_r - CW'(1);
            next_r  <= next_r + SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload and loop registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= gbns_pkg::action_t'(in_action);
      tag_r     <= in_message_tag;
      ack_r     <= in_ack_num;
      corrupt_r <= in_ack_corrupt;
    end
    case (state_r)
      gbns_pkg::ST_EVAL: begin
        ptr_r <= base_r;
        if (act_r == gbns_pkg::ACT_MSG) begin
          send_r <= 1'b1;
          left_r <= SW'(1);
        end else if ((act_r == gbns_pkg::ACT_ACK) && in_win) begin
          send_r <= 1'b1;
          left_r <= ack_off + SW'(1);
        end else begin
          send_r <= 1'b0;
          left_r <= in_flight;
        end
      end
      gbns_pkg::ST_EMIT: begin
        if (slot_free) begin
          left_r    <= left_r - SW'(1);
          ptr_r     <= ptr_r + SW'(1);
          out_last_r <= !more;
          if (send_r) begin
            out_kind_r <= gbns_pkg::KIND_NEW;
            out_seq_r  <= next_r;
            out_tag_r  <= pend_rdata;
          end else begin
            out_kind_r <= gbns_pkg::KIND_RESEND;
            out_seq_r  <= ptr_r;
            out_tag_r  <= flight_rdata;
          end
        end
      end
      gbns_pkg::ST_DROP: begin
        if (slot_free) begin
          out_kind_r <= gbns_pkg::KIND_DROP;
          out_seq_r  <= '0;
          out_tag_r  <= tag_r;
          out_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_seq_num = out_seq_r;
  assign out_out_tag = out_tag_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/core/go_back_n_sender_window_core.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core: go-back-n ARQ sender window
// Queues messages, sends them into a 7-packet window over 8 seq numbers, resends on timeout or duplicate ack.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries an action (message,
//    ack, timeout) plus its tag, ack number and corrupt flag.
//  - Result channel (out_valid / out_stall): sent, resent or dropped packets,
//    each with seq number and tag; out_last marks the final beat of an input.
//  - APB port holds pending_limit at byte 0 (reset 50, capped at 64).
//  - Order: a drop beat passes EVAL and DROP into the output register, a sent or
//    resent beat EVAL, RD and EMIT; then one beat per cycle while out_stall is low.
//  - An item with no result ends after EVAL, a drop goes through DROP, else RD
//    and EMIT give n sent or resent packets (up to 7); the single pending-FIFO /
//    window-tag read port paces the walk, one entry a cycle while out_stall is
//    low, with the next entry prefetched.
//  - in_stall is high from the accept until the last beat, if any, is loaded into the
//    output register; the next item can enter while that beat waits.
//  - A stalled result holds in the output register and the walk pauses.
//  - Reset clears window pointers, FIFO pointers and count; the memories
//    themselves are not cleared (only written entries are read).
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbns_pkg::ADDR_W-1:0]     paddr,
  input  logic [gbns_pkg::DATA_W-1:0]     pwdata,
  output logic [gbns_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [gbns_pkg::TAG_W-1:0]      in_message_tag,
  input  logic [gbns_pkg::SEQ_W-1:0]      in_ack_num,
  input  logic                            in_ack_corrupt,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [gbns_pkg::SEQ_W-1:0]      out_seq_num,
  output logic [gbns_pkg::TAG_W-1:0]      out_out_tag,
  output logic                            out_last
);

  logic [gbns_pkg::LIMIT_W-1:0] limit_r;
  logic                         reg_sel;

  gbns_pkg::pend_req_t          pend_req;
  gbns_pkg::flight_req_t        flight_req;
  logic [gbns_pkg::TAG_W-1:0]   pend_rdata, flight_rdata;

  // word index of the access
  assign reg_sel = (paddr[2] == gbns_pkg::REG_PENDING_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? gbns_pkg::DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= gbns_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_r <= pwdata[gbns_pkg::LIMIT_W-1:0];
    end
  end

  // pending message FIFO storage
  gbns_ram #(
    .DEPTH (gbns_pkg::FIFO_DEPTH),
    .WIDTH (gbns_pkg::TAG_W)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_req.we),
    .waddr (pend_req.waddr),
    .wdata (pend_req.wdata),
    .re    (pend_req.re),
    .raddr (pend_req.raddr),
    .rdata (pend_rdata)
  );

  // tags of packets in flight, indexed by seq number
  gbns_ram #(
    .DEPTH (gbns_pkg::SEQ_SPACE),
    .WIDTH (gbns_pkg::TAG_W)
  ) u_flight_ram (
    .clk   (clk),
    .we    (flight_req.we),
    .waddr (flight_req.waddr),
    .wdata (flight_req.wdata),
    .re    (flight_req.re),
    .raddr (flight_req.raddr),
    .rdata (flight_rdata)
  );

  gbns_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .pending_limit  (limit_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_message_tag (in_message_tag),
    .in_ack_num     (in_ack_num),
    .in_ack_corrupt (in_ack_corrupt),
    .pend_req       (pend_req),
    .pend_rdata     (pend_rdata),
    .flight_req     (flight_req),
    .flight_rdata   (flight_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_seq_num    (out_seq_num),
    .out_out_tag    (out_out_tag),
    .out_last       (out_last)
  );

endmodule
